[rtl/bcb_pkg.sv]
// Shared widths, result codes, register indexes and types for the bitmap blitter.
package bcb_pkg;

  localparam int DIM_W      = 13;
  localparam int POS_W      = 14;
  localparam int OFF_W      = 28;
  localparam int FCO_W      = 15;
  localparam int RB_W       = 15;
  localparam int COLOR_W    = 24;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;
  localparam int MAX_DIM    = 8192;

  localparam logic [KIND_W-1:0] KIND_FETCH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic PIXEL_BGR  = 1'b0;
  localparam logic PIXEL_BGRA = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd6;

  localparam logic [7:0] ALPHA_THRESHOLD = 8'd128;

  typedef struct packed {
    logic             command;
    logic [7:0]       blue;
    logic [7:0]       green;
    logic [7:0]       red;
    logic [7:0]       alpha;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [OFF_W-1:0]   source_offset;
    logic [DIM_W-1:0]   write_x;
    logic [DIM_W-1:0]   write_y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } result_t;

endpackage

[rtl/bcb_cmd_if.sv]
// Command/pixel input channel of the bitmap blitter.
interface bcb_cmd_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] alpha;

  modport source (output valid, command, blue, green, red, alpha, input ready);
  modport sink   (input valid, command, blue, green, red, alpha, output ready);
endinterface

[rtl/bcb_res_if.sv]
// Result channel of the bitmap blitter: fetch requests, pixel writes, done.
interface bcb_res_if;
  logic                          valid;
  logic                          ready;
  logic [bcb_pkg::KIND_W-1:0]    kind;
  logic [bcb_pkg::OFF_W-1:0]     source_offset;
  logic [bcb_pkg::DIM_W-1:0]     write_x;
  logic [bcb_pkg::DIM_W-1:0]     write_y;
  logic [bcb_pkg::COLOR_W-1:0]   color;
  logic                          last;

  modport source (output valid, kind, source_offset, write_x, write_y, color, last,
                  input ready);
  modport sink   (input valid, kind, source_offset, write_x, write_y, color, last,
                  output ready);
endinterface

[rtl/bitmap_clipped_blitter_top.sv]
// Clipped bitmap blitter: clips an image to the screen and walks the visible region.
// A start item clips the image to the screen and answers with the first fetch (or done
// when nothing is visible); each pixel item of a running blit answers with a screen
// write (skipped for 32-bit pixels whose alpha is 128 or less) and then the next fetch
// or done. Items pass an input register and combinational compute into a two-slot
// result buffer. An item that gives one result is taken every cycle while the result
// port is ready; a pixel that also writes gives two results and, since the port moves
// one per cycle, the next item is taken only as the second leaves. The start path holds
// the single 13x15 multiply (source row times padded row size) followed by one add.
module bitmap_clipped_blitter_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcb_pkg::CFG_DATA_W-1:0] cfg_data,
  bcb_cmd_if.sink                        cmd,
  bcb_res_if.source                      res
);
  import bcb_pkg::*;

  localparam logic [15:0] DIM_LIMIT = 16'(MAX_DIM - 1);

  // configuration
  logic [POS_W-1:0] dest_x;
  logic [POS_W-1:0] dest_y;
  logic [DIM_W-1:0] image_width;
  logic [POS_W-1:0] image_height;
  logic             pixel_mode;
  logic [DIM_W-1:0] fb_width;
  logic [DIM_W-1:0] fb_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x        <= '0;
      dest_y        <= '0;
      image_width   <= '0;
      image_height  <= '0;
      pixel_mode    <= 1'b0;
      fb_width      <= '0;
      fb_height     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEST_X:        dest_x        <= cfg_data[POS_W-1:0];
        CFG_DEST_Y:        dest_y        <= cfg_data[POS_W-1:0];
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  image_height  <= cfg_data[POS_W-1:0];
        CFG_PIXEL_MODE:    pixel_mode    <= cfg_data[0];
        CFG_SCREEN_WIDTH:  fb_width      <= cfg_data[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: fb_height     <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic q_valid;
  cmd_t q;
  logic advance;

  assign cmd.ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (cmd.ready) begin
      q_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      q <= '{command: cmd.command, blue: cmd.blue, green: cmd.green,
             red: cmd.red, alpha: cmd.alpha};
    end
  end

  // blit state
  logic             busy;
  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] row_count;
  logic [OFF_W-1:0] row_base_offset;
  logic [FCO_W-1:0] first_column_offset;
  logic [DIM_W-1:0] visible_start_x;
  logic [DIM_W-1:0] visible_start_y;
  logic [DIM_W-1:0] visible_width;
  logic [DIM_W-1:0] visible_height;

  // padded source row size in bytes
  logic [17:0]     bits24;
  logic [RB_W-1:0] row_bytes;
  logic            top_down;

  assign bits24    = {image_width, 4'b0} + {1'b0, image_width, 3'b0} + 18'd31;
  assign row_bytes = (pixel_mode == PIXEL_BGRA) ? {image_width, 2'b00}
                                                : {bits24[17:5], 2'b00};
  assign top_down  = image_height[POS_W-1];

  // start: clip the image rectangle
  logic signed [15:0] x_s, y_s, ex, ey, ex_c, ey_c, sx, sy, dw, dh, isx, isy, srow;
  logic [POS_W-1:0]   ah;
  logic               visible;
  logic [DIM_W-1:0]   dw_c, dh_c;
  logic [FCO_W-1:0]   start_fco;
  logic [DIM_W-1:0]   src_row;
  logic [OFF_W-1:0]   start_row_base;
  logic [OFF_W-1:0]   start_offset;

  always_comb begin
    x_s  = {{2{dest_x[POS_W-1]}}, dest_x};
    y_s  = {{2{dest_y[POS_W-1]}}, dest_y};
    ah   = top_down ? (~image_height + 14'd1) : image_height;
    ex   = x_s + {3'b0, image_width};
    ey   = y_s + {2'b0, ah};
    ex_c = (ex > $signed({3'b0, fb_width}))  ? $signed({3'b0, fb_width})  : ex;
    ey_c = (ey > $signed({3'b0, fb_height})) ? $signed({3'b0, fb_height}) : ey;
    sx   = x_s[15] ? 16'sd0 : x_s;
    sy   = y_s[15] ? 16'sd0 : y_s;
    visible = (sx < ex_c) && (sy < ey_c);
    dw   = ex_c - sx;
    dh   = ey_c - sy;
    dw_c = ($unsigned(dw) > DIM_LIMIT) ? DIM_LIMIT[DIM_W-1:0] : dw[DIM_W-1:0];
    dh_c = ($unsigned(dh) > DIM_LIMIT) ? DIM_LIMIT[DIM_W-1:0] : dh[DIM_W-1:0];
    isx  = sx - x_s;
    isy  = sy - y_s;
    srow = $signed({2'b0, ah}) - 16'sd1 - isy;
    start_fco = (pixel_mode == PIXEL_BGRA) ? {isx[12:0], 2'b00}
                                           : ({isx[13:0], 1'b0} + isx[14:0]);
    src_row = top_down ? isy[DIM_W-1:0] : srow[DIM_W-1:0];
    start_row_base = {15'b0, src_row} * {13'b0, row_bytes};
    start_offset   = start_row_base + {13'b0, start_fco};
  end

  // pixel: advance the walk
  logic [DIM_W:0]   col_inc;
  logic             row_wrap;
  logic [DIM_W-1:0] col_next, row_next;
  logic [OFF_W-1:0] row_base_next;
  logic [FCO_W-1:0] col_bytes;
  logic [OFF_W-1:0] walk_offset;
  logic             walk_done;
  logic             opaque;

  always_comb begin
    col_inc  = {1'b0, column_count} + 14'd1;
    row_wrap = col_inc >= {1'b0, visible_width};
    col_next = row_wrap ? '0 : col_inc[DIM_W-1:0];
    row_next = row_wrap ? row_count + 13'd1 : row_count;
    if (!row_wrap) begin
      row_base_next = row_base_offset;
    end else if (top_down) begin
      row_base_next = row_base_offset + {13'b0, row_bytes};
    end else begin
      row_base_next = row_base_offset - {13'b0, row_bytes};
    end
    col_bytes = (pixel_mode == PIXEL_BGRA) ? {col_next, 2'b00}
                                           : ({1'b0, col_next, 1'b0} + {2'b0, col_next});
    walk_offset = row_base_next + {13'b0, first_column_offset} + {13'b0, col_bytes};
    walk_done   = row_next >= visible_height;
    opaque      = (pixel_mode == PIXEL_BGR) || (q.alpha > ALPHA_THRESHOLD);
  end

  // results of the item in the input register
  result_t    r0, r1, tail;
  logic [1:0] n_res;

  always_comb begin
    r0    = '0;
    r1    = '0;
    tail  = '0;
    n_res = 2'd0;
    if (q.command == CMD_START) begin
      r0.kind          = visible ? KIND_FETCH : KIND_DONE;
      r0.source_offset = visible ? start_offset : '0;
      r0.last          = 1'b1;
      n_res            = 2'd1;
    end else if (busy) begin
      tail.kind          = walk_done ? KIND_DONE : KIND_FETCH;
      tail.source_offset = walk_done ? '0 : walk_offset;
      tail.last          = 1'b1;
      if (opaque) begin
        r0.kind     = KIND_WRITE;
        r0.write_x  = visible_start_x + column_count;
        r0.write_y  = visible_start_y + row_count;
        r0.color    = {q.red, q.green, q.blue};
        r1          = tail;
        n_res       = 2'd2;
      end else begin
        r0    = tail;
        n_res = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy                <= 1'b0;
      column_count        <= '0;
      row_count           <= '0;
      row_base_offset     <= '0;
      first_column_offset <= '0;
      visible_start_x     <= '0;
      visible_start_y     <= '0;
      visible_width       <= '0;
      visible_height      <= '0;
    end else if (advance) begin
      if (q.command == CMD_START) begin
        busy <= visible;
        if (visible) begin
          column_count        <= '0;
          row_count           <= '0;
          row_base_offset     <= start_row_base;
          first_column_offset <= start_fco;
          visible_start_x     <= sx[DIM_W-1:0];
          visible_start_y     <= sy[DIM_W-1:0];
          visible_width       <= dw_c;
          visible_height      <= dh_c;
        end
      end else if (busy) begin
        column_count    <= col_next;
        row_count       <= row_next;
        row_base_offset <= row_base_next;
        busy            <= !walk_done;
      end
    end
  end

  // two-slot result buffer; slot0 drives the port
  result_t    slot0, slot1;
  logic [1:0] cnt;
  logic       pop;

  assign pop     = res.valid && res.ready;
  assign advance = q_valid && ((cnt == 2'd0) || ((cnt == 2'd1) && pop));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (advance) begin
      cnt <= n_res;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign res.valid         = cnt != 2'd0;
  assign res.kind          = slot0.kind;
  assign res.source_offset = slot0.source_offset;
  assign res.write_x       = slot0.write_x;
  assign res.write_y       = slot0.write_y;
  assign res.color         = slot0.color;
  assign res.last          = slot0.last;

endmodule

[verif/tb_bitmap_clipped_blitter_top.sv]
// Self-checking testbench for the clipped bitmap blitter: directed rows, a back-pressure run, then random blits.
`timescale 1ns / 1ps

module tb_bitmap_clipped_blitter_top;
  import bcb_pkg::*;

  localparam int ITEM_TARGET = 1500;
  localparam int CALM_ITEMS  = 150;
  localparam int DRAIN_GAP   = 4;
  localparam int LONG_HOLD   = 320;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PIXEL_CAP   = 64;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [2:0]        idx;
    logic [13:0]       data;
    logic              command;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    logic [7:0]        alpha;
    bit                typed;
    logic [KIND_W-1:0] res_kind;
    logic [OFF_W-1:0]  res_off;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bcb_cmd_if cmd_ch ();
  bcb_res_if res_ch ();

  bitmap_clipped_blitter_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  always #6 clk = ~clk;

  // register shadow
  logic signed [13:0] reg_dest_x, reg_dest_y, reg_img_h;
  logic [12:0]        reg_img_w, reg_scr_w, reg_scr_h;
  logic               reg_mode;

  // blit walk state
  bit          blit_on;
  int unsigned col_idx, row_idx, clip_x, clip_y, clip_w, clip_h;
  logic [27:0] src_row_base;
  logic [14:0] col0_offset;

  result_t step_ops [2];
  int      op_count;
  bit      item_ignored;
  result_t outstanding_ops [$];

  int  failures, total_items, live_items, starts_seen, directed_items;
  int  fetch_seen, write_seen, done_seen, long_holds;
  int  cycle_count;
  bit  calm, hold_long;

  stim_row_t directed_rows [0:42] = '{
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_DONE, 28'd0},
    // pixel with no blit running
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0, KIND_DONE, 28'd0},
    '{ROW_REG, CFG_SCREEN_WIDTH, 14'd8191, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_SCREEN_HEIGHT, 14'd8191, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_IMAGE_WIDTH, 14'd3, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_IMAGE_HEIGHT, 14'd2, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    // bottom-up 3x2 BGR: first fetch is the second stored row, 12 bytes per padded row
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_FETCH, 28'd12},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'h01, 8'h02, 8'h04, 8'h00, 1'b0, KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'h80, 8'h40, 8'h20, 8'h10, 1'b0, KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'h55, 8'haa, 8'h0f, 8'hf0, 1'b0, KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'hfe, 8'h7f, 8'h01, 8'h81, 1'b0, KIND_DONE, 28'd0},
    '{ROW_REG, CFG_PIXEL_MODE, 14'(PIXEL_BGRA), CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_IMAGE_WIDTH, 14'd2, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_IMAGE_HEIGHT, 14'(-3), CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_DEST_X, 14'(-1), CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_DEST_Y, 14'(-1), CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    // top-down, clipped left and top: row 1, column 1 of an 8-byte row
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_FETCH, 28'd12},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'h12, 8'h34, 8'h56, 8'd128, 1'b0, KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'h9a, 8'hbc, 8'hde, 8'd129, 1'b0, KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'h01, 8'h01, 8'h01, 8'hff, 1'b0, KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_FETCH, 28'd12},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'hff, 8'h00, 8'hff, 8'hff, 1'b0, KIND_DONE, 28'd0},
    // restart while a blit is running
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_FETCH, 28'd12},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'hff, 8'hff, 8'hff, 8'h00, 1'b0, KIND_DONE, 28'd0},
    '{ROW_REG, CFG_DEST_X, 14'd8191, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_DONE, 28'd0},
    '{ROW_REG, CFG_DEST_X, 14'(-8192), CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_IMAGE_WIDTH, 14'd8191, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_DONE, 28'd0},
    '{ROW_REG, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_DEST_Y, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_IMAGE_HEIGHT, 14'(-8192), CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_PIXEL_MODE, 14'(PIXEL_BGR), CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    // full-screen top-down image starts at offset zero
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_FETCH, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'h3c, 8'hc3, 8'h5a, 8'h00, 1'b0, KIND_DONE, 28'd0},
    '{ROW_REG, CFG_IMAGE_HEIGHT, 14'd8191, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_REG, CFG_PIXEL_MODE, 14'(PIXEL_BGRA), CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_PIXEL, 8'ha5, 8'h5a, 8'hc3, 8'd200, 1'b0, KIND_DONE, 28'd0},
    '{ROW_REG, CFG_SCREEN_WIDTH, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
      KIND_DONE, 28'd0},
    '{ROW_ITEM, CFG_DEST_X, 14'd0, CMD_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, KIND_DONE, 28'd0}
  };

  function automatic result_t make_op(input logic [KIND_W-1:0] kind, input logic [OFF_W-1:0] off,
                                      input logic [DIM_W-1:0] sx, input logic [DIM_W-1:0] sy,
                                      input logic [COLOR_W-1:0] color);
    result_t op;
    op.kind          = kind;
    op.source_offset = off;
    op.write_x       = sx;
    op.write_y       = sy;
    op.color         = color;
    op.last          = 1'b0;
    return op;
  endfunction

  function automatic int unsigned padded_row_bytes();
    int unsigned w, bits;
    w    = 32'(reg_img_w);
    bits = (reg_mode == PIXEL_BGRA) ? 32 : 24;
    return ((w * bits + 31) / 32) * 4;
  endfunction

  function automatic logic [OFF_W-1:0] next_fetch_offset(input int unsigned bpp);
    return 28'(src_row_base + col0_offset + col_idx * bpp);
  endfunction

  function automatic void apply_reg_write(input logic [2:0] idx, input logic [13:0] data);
    case (idx)
      CFG_DEST_X:        reg_dest_x = data;
      CFG_DEST_Y:        reg_dest_y = data;
      CFG_IMAGE_WIDTH:   reg_img_w  = data[12:0];
      CFG_IMAGE_HEIGHT:  reg_img_h  = data;
      CFG_PIXEL_MODE:    reg_mode   = data[0];
      CFG_SCREEN_WIDTH:  reg_scr_w  = data[12:0];
      CFG_SCREEN_HEIGHT: reg_scr_h  = data[12:0];
      default: ;
    endcase
  endfunction

  // Fills step_ops with what one accepted item makes the blitter emit.
  function automatic void compute_blit_ops(input logic command, input logic [7:0] b,
                                           input logic [7:0] g, input logic [7:0] r,
                                           input logic [7:0] a);
    int x, y, h, ah, iw, sw, sh, sx, sy, ex, ey, dw, dh, isx, isy;
    int unsigned src_row, bpp;
    bit top_down;
    op_count     = 0;
    item_ignored = 1'b0;
    bpp = (reg_mode == PIXEL_BGRA) ? 4 : 3;
    if (command == CMD_START) begin
      starts_seen++;
      x  = int'(reg_dest_x);
      y  = int'(reg_dest_y);
      h  = int'(reg_img_h);
      iw = int'(reg_img_w);
      sw = int'(reg_scr_w);
      sh = int'(reg_scr_h);
      top_down = (h < 0);
      ah = top_down ? -h : h;
      sx = (x < 0) ? 0 : x;
      sy = (y < 0) ? 0 : y;
      ex = x + iw;
      ey = y + ah;
      if (ex > sw) ex = sw;
      if (ey > sh) ey = sh;
      if (sx >= ex || sy >= ey) begin
        blit_on = 1'b0;
        step_ops[0] = make_op(KIND_DONE, '0, '0, '0, '0);
      end else begin
        dw  = ex - sx;
        dh  = ey - sy;
        if (dw > MAX_DIM - 1) dw = MAX_DIM - 1;
        if (dh > MAX_DIM - 1) dh = MAX_DIM - 1;
        isx = sx - x;
        isy = sy - y;
        src_row = top_down ? isy : (ah - 1 - isy);
        clip_x = sx;
        clip_y = sy;
        clip_w = dw;
        clip_h = dh;
        col0_offset  = 15'(isx * bpp);
        src_row_base = 28'(src_row * padded_row_bytes());
        col_idx = 0;
        row_idx = 0;
        blit_on = 1'b1;
        step_ops[0] = make_op(KIND_FETCH, next_fetch_offset(bpp), '0, '0, '0);
      end
      step_ops[0].last = 1'b1;
      op_count = 1;
    end else if (!blit_on) begin
      item_ignored = 1'b1;
    end else begin
      // transparent 32-bit pixels skip the write but still advance
      if (reg_mode == PIXEL_BGR || a > ALPHA_THRESHOLD) begin
        step_ops[op_count] = make_op(KIND_WRITE, '0, 13'(clip_x + col_idx),
                                     13'(clip_y + row_idx), {r, g, b});
        op_count++;
      end
      col_idx++;
      if (col_idx >= clip_w) begin
        col_idx = 0;
        row_idx++;
        if (reg_img_h < 0) src_row_base = 28'(src_row_base + padded_row_bytes());
        else               src_row_base = 28'(src_row_base - padded_row_bytes());
      end
      col_idx = col_idx & 32'h1fff;
      row_idx = row_idx & 32'h1fff;
      if (row_idx >= clip_h) begin
        blit_on = 1'b0;
        step_ops[op_count] = make_op(KIND_DONE, '0, '0, '0, '0);
      end else begin
        step_ops[op_count] = make_op(KIND_FETCH, next_fetch_offset(bpp), '0, '0, '0);
      end
      step_ops[op_count].last = 1'b1;
      op_count++;
    end
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  task automatic send_item(input logic command, input logic [7:0] b, input logic [7:0] g,
                           input logic [7:0] r, input logic [7:0] a, input bit typed,
                           input result_t typed_op);
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.command <= command;
    cmd_ch.blue    <= b;
    cmd_ch.green   <= g;
    cmd_ch.red     <= r;
    cmd_ch.alpha   <= a;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    compute_blit_ops(command, b, g, r, a);
    if (typed) outstanding_ops.push_back(typed_op);
    else for (int k = 0; k < op_count; k++) outstanding_ops.push_back(step_ops[k]);
    total_items++;
    if (!item_ignored) live_items++;
    calm = (live_items >= ITEM_TARGET - CALM_ITEMS);
  endtask

  task automatic send_pixels(input int count);
    logic [7:0] a;
    for (int k = 0; k < count; k++) begin
      // bias alpha toward the transparency threshold now and then
      a = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(126, 130)) : 8'($urandom);
      send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), a, 1'b0, '0);
    end
  endtask

  // stop offering, let every pending result out, then cover any result-less item in flight
  task automatic drain_block();
    cmd_ch.valid <= 1'b0;
    while (outstanding_ops.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [13:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg_write(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setup();
    if ($urandom_range(0, 7) != 0)
      write_reg(CFG_DEST_X, ($urandom_range(0, 5) == 0) ? 14'($urandom)
                                                         : 14'($urandom_range(0, 40) - 12));
    if ($urandom_range(0, 7) != 0)
      write_reg(CFG_DEST_Y, ($urandom_range(0, 5) == 0) ? 14'($urandom)
                                                         : 14'($urandom_range(0, 40) - 12));
    if ($urandom_range(0, 7) != 0)
      write_reg(CFG_IMAGE_WIDTH, ($urandom_range(0, 5) == 0) ? 14'($urandom_range(0, 8191))
                                                              : 14'($urandom_range(0, 8)));
    if ($urandom_range(0, 7) != 0)
      write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(0, 5) == 0) ? 14'($urandom)
                                                               : 14'($urandom_range(0, 16) - 8));
    if ($urandom_range(0, 7) != 0)
      write_reg(CFG_PIXEL_MODE, $urandom_range(0, 1) ? 14'(PIXEL_BGRA) : 14'(PIXEL_BGR));
    if ($urandom_range(0, 7) != 0)
      write_reg(CFG_SCREEN_WIDTH, ($urandom_range(0, 5) == 0) ? 14'($urandom_range(0, 8191))
                                                               : 14'($urandom_range(0, 16)));
    if ($urandom_range(0, 7) != 0)
      write_reg(CFG_SCREEN_HEIGHT, ($urandom_range(0, 5) == 0) ? 14'($urandom_range(0, 8191))
                                                                : 14'($urandom_range(0, 16)));
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (outstanding_ops.size() == 0) begin
        note_failure($sformatf("unexpected result: kind=%0d off=%0h x=%0d y=%0d color=%06h last=%0d",
                               res_ch.kind, res_ch.source_offset, res_ch.write_x,
                               res_ch.write_y, res_ch.color, res_ch.last));
      end else begin
        want = outstanding_ops.pop_front();
        if (res_ch.kind !== want.kind || res_ch.source_offset !== want.source_offset ||
            res_ch.write_x !== want.write_x || res_ch.write_y !== want.write_y ||
            res_ch.color !== want.color || res_ch.last !== want.last) begin
          note_failure($sformatf({"mismatch: want kind=%0d off=%0h x=%0d y=%0d color=%06h ",
                                  "last=%0d, got kind=%0d off=%0h x=%0d y=%0d color=%06h last=%0d"},
                                 want.kind, want.source_offset, want.write_x, want.write_y,
                                 want.color, want.last, res_ch.kind, res_ch.source_offset,
                                 res_ch.write_x, res_ch.write_y, res_ch.color, res_ch.last));
        end
        case (want.kind)
          KIND_FETCH: fetch_seen++;
          KIND_WRITE: write_seen++;
          default:    done_seen++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               outstanding_ops.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request, none near the end
  initial begin
    res_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
        long_holds++;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    result_t typed_op;
    bit      regs_quiet;
    int      area, count;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_DEST_X;
    cfg_data       <= '0;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.command <= CMD_START;
    cmd_ch.blue    <= '0;
    cmd_ch.green   <= '0;
    cmd_ch.red     <= '0;
    cmd_ch.alpha   <= '0;
    reg_dest_x = '0; reg_dest_y = '0; reg_img_w = '0; reg_img_h = '0;
    reg_mode   = PIXEL_BGR; reg_scr_w = '0; reg_scr_h = '0;
    blit_on = 1'b0; col_idx = 0; row_idx = 0; src_row_base = '0; col0_offset = '0;
    clip_x = 0; clip_y = 0; clip_w = 0; clip_h = 0;
    regs_quiet = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        if (!regs_quiet) drain_block();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
        regs_quiet = 1'b1;
      end else begin
        regs_quiet = 1'b0;
        typed_op = make_op(directed_rows[i].res_kind, directed_rows[i].res_off, '0, '0, '0);
        typed_op.last = 1'b1;
        send_item(directed_rows[i].command, directed_rows[i].blue, directed_rows[i].green,
                  directed_rows[i].red, directed_rows[i].alpha, directed_rows[i].typed, typed_op);
      end
    end
    directed_items = total_items;

    // back-pressure run: an 8x8 image streamed while the result side holds off
    drain_block();
    write_reg(CFG_SCREEN_WIDTH, 14'd16);
    write_reg(CFG_SCREEN_HEIGHT, 14'd16);
    write_reg(CFG_DEST_X, 14'd0);
    write_reg(CFG_DEST_Y, 14'd0);
    write_reg(CFG_IMAGE_WIDTH, 14'd8);
    write_reg(CFG_IMAGE_HEIGHT, 14'd8);
    write_reg(CFG_PIXEL_MODE, 14'(PIXEL_BGR));
    hold_long = 1'b1;
    send_item(CMD_START, '0, '0, '0, '0, 1'b0, '0);
    send_pixels(64);

    while (live_items < ITEM_TARGET) begin
      drain_block();
      random_setup();
      // a blit left running keeps going under the new registers
      if (blit_on && $urandom_range(0, 1) == 1) send_pixels($urandom_range(1, 4));
      repeat ($urandom_range(1, 3)) begin
        send_item(CMD_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
        if (blit_on) begin
          area  = clip_w * clip_h;
          count = (area > PIXEL_CAP) ? PIXEL_CAP : area;
          if ($urandom_range(0, 5) == 0) count = $urandom_range(0, count);
          send_pixels(count);
        end
        if ($urandom_range(0, 3) == 0) send_pixels($urandom_range(1, 2));
      end
    end

    cmd_ch.valid <= 1'b0;
    while (outstanding_ops.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Covered %0d items (%0d directed, %0d live), %0d blit starts, %0d long hold-offs",
             total_items, directed_items, live_items, starts_seen, long_holds);
    $display("Checked %0d fetches, %0d pixel writes, %0d done; %0d failures",
             fetch_seen, write_seen, done_seen, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bcb_pkg.sv
rtl/bcb_cmd_if.sv
rtl/bcb_res_if.sv
rtl/bitmap_clipped_blitter_top.sv
verif/tb_bitmap_clipped_blitter_top.sv
